### sv/faulty_memory_cell_model_top_assert.svh
// ----------------------------------------------------------------------------
// faulty memory cell model assertion macros
// shared property wrappers for the model's internal checks
// ----------------------------------------------------------------------------
`ifndef FAULTY_MEMORY_CELL_MODEL_TOP_ASSERT_SVH
`define FAULTY_MEMORY_CELL_MODEL_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FMCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FMCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fmcm_pkg.sv
// ----------------------------------------------------------------------------
// fmcm_pkg
// shared types and constants of the faulty memory cell model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmcm_pkg;

    // fixed field widths
    localparam int ADDR_IN_W   = 8;
    localparam int ADDR_SPAN   = 1 << ADDR_IN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;
    localparam int STEPS_IN_OPS = 4;

    // access kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // fault modes
    localparam logic [1:0] MODE_ONE_CELL = 2'd0;
    localparam logic [1:0] MODE_AGG_SENS = 2'd1;
    localparam logic [1:0] MODE_VIC_SENS = 2'd2;
    localparam logic [1:0] MODE_NONE     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VICTIM_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AGGR_ADDR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_OPS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_VALUE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_READ   = 3'd7;

    // queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // one history record: value before, kind, access value
    typedef logic [2:0] t_rec;

    // trigger settings seen by the back end
    typedef struct packed {
        logic [2:0] trigger_length;
        logic [7:0] trigger_ops;
        logic       fault_value;
        logic       final_read_value;
    } t_cfg;

    // classified access, without its address
    typedef struct packed {
        logic is_read;
        logic value;
        logic is_sens;
        logic two_cell;
        logic sens_init;
        logic cpl_init;
    } t_item_ctl;

endpackage

### sv/fmcm_ram.sv
// ----------------------------------------------------------------------------
// fmcm_ram
// generic memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmcm_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_a,
    output logic [DATA_W-1:0]        o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### sv/fmcm_front.sv
// ----------------------------------------------------------------------------
// fmcm_front
// configuration registers, input acceptance and access classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmcm_front #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fmcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fmcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_tvalid,
    input  logic [fmcm_pkg::S_TDATA_W-1:0]      i_tdata,
    input  logic                                i_tuser,
    input  logic                                i_space,
    output logic                                o_tready,
    output logic                                o_push,
    output fmcm_pkg::t_item_ctl                 o_item_ctl,
    output logic [$clog2(MEM_DEPTH)-1:0]        o_item_addr,
    output logic [$clog2(MEM_DEPTH)-1:0]        o_vic_addr,
    output logic [$clog2(MEM_DEPTH)-1:0]        o_cpl_addr,
    output fmcm_pkg::t_cfg                      o_cfg,
    output logic                                o_cfg_clear
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [1:0] r_fault_mode;
    logic [7:0] r_victim_address;
    logic [7:0] r_aggressor_address;
    logic [1:0] r_initial_values;
    logic [2:0] r_trigger_length;
    logic [7:0] r_trigger_ops;
    logic       r_fault_value;
    logic       r_final_read_value;

    logic [AW-1:0] w_mod_tab [fmcm_pkg::ADDR_SPAN];
    logic [AW-1:0] w_addr;
    logic [AW-1:0] w_vic;
    logic [AW-1:0] w_agg;
    logic [AW-1:0] w_sens;
    logic          w_agg_mode;
    logic          w_two_cell;

    // register writes, each index owns one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_mode        <= fmcm_pkg::MODE_ONE_CELL;
            r_victim_address    <= 8'd0;
            r_aggressor_address <= 8'd1;
            r_initial_values    <= 2'd0;
            r_trigger_length    <= 3'd1;
            r_trigger_ops       <= 8'd0;
            r_fault_value       <= 1'b0;
            r_final_read_value  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fmcm_pkg::REG_FAULT_MODE:  r_fault_mode        <= i_cfg_data[1:0];
                fmcm_pkg::REG_VICTIM_ADDR: r_victim_address    <= i_cfg_data;
                fmcm_pkg::REG_AGGR_ADDR:   r_aggressor_address <= i_cfg_data;
                fmcm_pkg::REG_INIT_VALUES: r_initial_values    <= i_cfg_data[1:0];
                fmcm_pkg::REG_TRIG_LENGTH: r_trigger_length    <= i_cfg_data[2:0];
                fmcm_pkg::REG_TRIG_OPS:    r_trigger_ops       <= i_cfg_data;
                fmcm_pkg::REG_FAULT_VALUE: r_fault_value       <= i_cfg_data[0];
                fmcm_pkg::REG_FINAL_READ:  r_final_read_value  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // address reduction table, constant per depth
    for (genvar g = 0; g < fmcm_pkg::ADDR_SPAN; g++) begin : g_mod
        assign w_mod_tab[g] = AW'(g % MEM_DEPTH);
    end

    assign w_addr = w_mod_tab[i_tdata[fmcm_pkg::ADDR_IN_W-1:0]];
    assign w_vic  = w_mod_tab[r_victim_address];
    assign w_agg  = w_mod_tab[r_aggressor_address];

    // sensitizing and coupled cells per mode
    assign w_agg_mode = (r_fault_mode == fmcm_pkg::MODE_AGG_SENS);
    assign w_two_cell = w_agg_mode || (r_fault_mode == fmcm_pkg::MODE_VIC_SENS);
    assign w_sens     = w_agg_mode ? w_agg : w_vic;

    // input handshake straight into the queue
    assign o_tready = i_space;
    assign o_push   = i_tvalid && i_space;

    // classification of the access
    always_comb begin
        o_item_ctl.is_read   = (i_tuser == fmcm_pkg::CMD_READ);
        o_item_ctl.value     = i_tdata[fmcm_pkg::ADDR_IN_W];
        o_item_ctl.is_sens   = (w_addr == w_sens) && (r_fault_mode != fmcm_pkg::MODE_NONE);
        o_item_ctl.two_cell  = w_two_cell;
        o_item_ctl.sens_init = w_agg_mode ? r_initial_values[1] : r_initial_values[0];
        o_item_ctl.cpl_init  = w_agg_mode ? r_initial_values[0] : r_initial_values[1];
    end

    assign o_item_addr = w_addr;
    assign o_vic_addr  = w_vic;
    assign o_cpl_addr  = w_agg_mode ? w_vic : w_agg;

    // trigger settings for the back end
    assign o_cfg.trigger_length   = r_trigger_length;
    assign o_cfg.trigger_ops      = r_trigger_ops;
    assign o_cfg.fault_value      = r_fault_value;
    assign o_cfg.final_read_value = r_final_read_value;

    // any register write restarts the history
    assign o_cfg_clear = i_cfg_wr_en;

endmodule

### sv/fmcm_queue.sv
// ----------------------------------------------------------------------------
// fmcm_queue
// two-entry queue of classified accesses between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmcm_queue #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]                       r_mem [fmcm_pkg::QUEUE_DEPTH];
    logic [fmcm_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [fmcm_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [fmcm_pkg::QUEUE_CNT_W-1:0]   r_count;

    assign o_full  = (r_count == fmcm_pkg::QUEUE_CNT_W'(fmcm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/fmcm_back.sv
// ----------------------------------------------------------------------------
// fmcm_back
// cell memory, operation history, trigger match and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "faulty_memory_cell_model_top_assert.svh"

module fmcm_back #(
    parameter int MEM_DEPTH   = 256,
    parameter int MAX_TRIGGER = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  fmcm_pkg::t_item_ctl            i_q_ctl,
    input  logic [$clog2(MEM_DEPTH)-1:0]   i_q_addr,
    output logic                           o_pop,
    input  logic [$clog2(MEM_DEPTH)-1:0]   i_vic_addr,
    input  logic [$clog2(MEM_DEPTH)-1:0]   i_cpl_addr,
    input  fmcm_pkg::t_cfg                 i_cfg,
    input  logic                           i_cfg_clear,
    output logic                           o_clearing,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic                           o_read_data,
    output logic                           o_fault_fired
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int LW = $clog2(MAX_TRIGGER + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       n_clr_addr;
    fmcm_pkg::t_item_ctl r_ctl;
    logic [AW-1:0]       r_addr;
    fmcm_pkg::t_rec      r_hist [MAX_TRIGGER];
    logic [LW-1:0]       r_hist_cnt;
    logic                r_out_valid;
    logic                r_out_rd;
    logic                r_out_fired;

    logic                w_commit;
    logic                w_before;
    logic                w_cpl;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_wdata;
    logic [AW-1:0]       w_raddr_a;
    fmcm_pkg::t_rec      w_new_hist [MAX_TRIGGER];
    logic [LW-1:0]       w_new_cnt;
    logic [LW-1:0]       w_eff_len;
    logic [1:0]          w_step [MAX_TRIGGER];
    fmcm_pkg::t_rec      w_expect [MAX_TRIGGER];
    logic                w_seq_ok;
    logic                w_hit;

    // cell storage
    fmcm_ram #(
        .DATA_W (1),
        .DEPTH  (MEM_DEPTH)
    ) u_cells (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (i_cpl_addr),
        .o_rdata_a (w_before),
        .o_rdata_b (w_cpl)
    );

    // read address holds during the look cycle
    assign w_raddr_a = (r_state == ST_LOOK) ? r_addr : i_q_addr;

    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign w_commit   = (r_state == ST_LOOK) && (!r_out_valid || i_m_tready);
    assign o_clearing = (r_state == ST_CLEAR);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // history shift and effective trigger length
    always_comb begin
        w_new_hist[0] = {w_before, r_ctl.is_read, r_ctl.value};
        for (int i = 1; i < MAX_TRIGGER; i++) begin
            w_new_hist[i] = r_hist[i-1];
        end
        w_new_cnt = (r_hist_cnt == LW'(MAX_TRIGGER)) ? r_hist_cnt : r_hist_cnt + 1'b1;
        if (i_cfg.trigger_length == '0) begin
            w_eff_len = LW'(1);
        end else if (int'(i_cfg.trigger_length) > MAX_TRIGGER) begin
            w_eff_len = LW'(MAX_TRIGGER);
        end else begin
            w_eff_len = LW'(i_cfg.trigger_length);
        end
    end

    // expected records, each step chained to the value of the one before
    always_comb begin
        for (int i = 0; i < MAX_TRIGGER; i++) begin
            w_step[i] = 2'(i_cfg.trigger_ops >> (2 * i));
        end
        w_expect[0] = {r_ctl.sens_init, w_step[0]};
        for (int i = 1; i < MAX_TRIGGER; i++) begin
            w_expect[i] = {w_step[i-1][0], w_step[i]};
        end
    end

    // oldest used record pairs with the first step
    always_comb begin
        w_seq_ok = 1'b1;
        for (int i = 0; i < MAX_TRIGGER; i++) begin
            for (int j = 0; j < MAX_TRIGGER; j++) begin
                if ((i + j + 1) == int'(w_eff_len) && w_new_hist[j] != w_expect[i]) begin
                    w_seq_ok = 1'b0;
                end
            end
        end
        w_hit = r_ctl.is_sens && (w_new_cnt >= w_eff_len) && w_seq_ok
                && (!r_ctl.two_cell || (w_cpl == r_ctl.cpl_init));
    end

    // memory write: clearing sweep, fault into the victim, or plain write
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = 1'b0;
        end else begin
            w_we    = w_commit && (w_hit || !r_ctl.is_read);
            w_waddr = w_hit ? i_vic_addr : r_addr;
            w_wdata = w_hit ? i_cfg.fault_value : r_ctl.value;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_hist_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_clear) begin
                r_hist_cnt <= '0;
            end else if (w_commit && r_ctl.is_sens) begin
                r_hist_cnt <= w_new_cnt;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl  <= i_q_ctl;
            r_addr <= i_q_addr;
        end
        if (w_commit && r_ctl.is_sens) begin
            r_hist <= w_new_hist;
        end
        if (w_commit) begin
            r_out_fired <= w_hit;
            if (!r_ctl.is_read) begin
                r_out_rd <= 1'b0;
            end else if (w_hit) begin
                r_out_rd <= i_cfg.final_read_value;
            end else begin
                r_out_rd <= w_before;
            end
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_read_data   = r_out_rd;
    assign o_fault_fired = r_out_fired;

    // checks
    `FMCM_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !o_pop, "pop during clearing pass")
    `FMCM_ASSERT_NOW(a_hist_cnt_bound, i_clk, i_rst_n, 1'b1, int'(r_hist_cnt) <= MAX_TRIGGER, "history count over depth")
    `FMCM_ASSERT_NEXT(a_commit_to_idle, i_clk, i_rst_n, w_commit, r_state == ST_IDLE && r_out_valid, "commit did not return to idle with a result")
    `FMCM_ASSERT_NEXT(a_fire_reported, i_clk, i_rst_n, w_commit && w_hit, r_out_fired, "fault fired but not reported")

endmodule

### sv/faulty_memory_cell_model_top.sv
// ----------------------------------------------------------------------------
// faulty_memory_cell_model_top
// bit memory that emulates one configured memory fault primitive
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each accepted access produces exactly one result word. The front end
// takes an access in any cycle with room in its two-entry queue; the back
// end then handles it in two steps, an idle step that pops it and reads
// the addressed and coupled cells from the registered-read cell memory
// and a look step that matches the history and writes back, held while
// the result register waits on m_axis_tready, before it pops the next.
// After reset the cell memory is swept to zero, one cell a cycle, over
// all MEM_DEPTH cells with s_axis_tready low; configuration writes are
// taken throughout and clear the operation history.

module faulty_memory_cell_model_top #(
    parameter int MEM_DEPTH   = 256,
    parameter int MAX_TRIGGER = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [fmcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fmcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // access stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fmcm_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] address, [8] op_value
    input  logic                                s_axis_tuser,  // [0] command
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fmcm_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [0] read_data
    output logic                                m_axis_tuser   // [0] fault_fired
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int QW  = $bits(fmcm_pkg::t_item_ctl) + AW;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_valid;
    logic                 w_clearing;
    logic                 w_space;
    logic                 w_cfg_clear;
    logic                 w_read_data;
    fmcm_pkg::t_item_ctl  w_item_ctl;
    fmcm_pkg::t_item_ctl  w_q_ctl;
    fmcm_pkg::t_cfg       w_cfg;
    logic [AW-1:0]        w_item_addr;
    logic [AW-1:0]        w_q_addr;
    logic [AW-1:0]        w_vic_addr;
    logic [AW-1:0]        w_cpl_addr;
    logic [QW-1:0]        w_q_out;

    assign w_space = !w_q_full && !w_clearing;

    // accept and classify
    fmcm_front #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (s_axis_tvalid),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_space     (w_space),
        .o_tready    (s_axis_tready),
        .o_push      (w_push),
        .o_item_ctl  (w_item_ctl),
        .o_item_addr (w_item_addr),
        .o_vic_addr  (w_vic_addr),
        .o_cpl_addr  (w_cpl_addr),
        .o_cfg       (w_cfg),
        .o_cfg_clear (w_cfg_clear)
    );

    // decoupling queue
    fmcm_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_item_ctl, w_item_addr}),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign w_q_ctl  = w_q_out[QW-1:AW];
    assign w_q_addr = w_q_out[AW-1:0];

    // execute against the cell memory
    fmcm_back #(
        .MEM_DEPTH   (MEM_DEPTH),
        .MAX_TRIGGER (MAX_TRIGGER)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_ctl       (w_q_ctl),
        .i_q_addr      (w_q_addr),
        .o_pop         (w_pop),
        .i_vic_addr    (w_vic_addr),
        .i_cpl_addr    (w_cpl_addr),
        .i_cfg         (w_cfg),
        .i_cfg_clear   (w_cfg_clear),
        .o_clearing    (w_clearing),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_read_data   (w_read_data),
        .o_fault_fired (m_axis_tuser)
    );

    assign m_axis_tdata = {(fmcm_pkg::M_TDATA_W - 1)'(0), w_read_data};

endmodule
